>>> design/id_ordered_chunk_reorder_buffer_macros.svh
// Assertion macros for the id ordered chunk reorder buffer.
// Included by the top level; no other dependencies.
`ifndef ID_ORDERED_CHUNK_REORDER_BUFFER_MACROS_SVH
`define ID_ORDERED_CHUNK_REORDER_BUFFER_MACROS_SVH

`ifndef SYNTH
`define OCRB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("reorder buffer assertion failed");
`define OCRB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("reorder buffer sequencing assertion failed");
`else
`define OCRB_ASSERT(lbl, clk, rst, prop)
`define OCRB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> design/ocrb_pkg.sv
// Shared types and constants of the id ordered chunk reorder buffer.
// No dependencies; imported by the controller, datapath and top level.
package ocrb_pkg;

  localparam int BUFFER_DEPTH = 16;
  localparam int COUNT_W      = $clog2(BUFFER_DEPTH + 1);
  localparam int ID_W         = 32;
  localparam int TS_W         = 40;
  localparam int HANDLE_W     = 16;
  localparam int SIZE_W       = 16;
  localparam int INTERVAL_W   = 20;
  localparam int TOTAL_W      = 48;
  localparam int REMAIN_W     = TOTAL_W + 2;
  localparam int BUDGET_LIMIT = 1000000;
  localparam int CHUNK_TIME   = 33400;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [TS_W-1:0]     ts;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } entry_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

>>> design/ocrb_ctrl.sv
// Controller of the reorder buffer: takes one beat, then runs the update.
// Depends on ocrb_pkg.
module ocrb_ctrl import ocrb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = !status.out_busy;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> design/ocrb_dp.sv
// Datapath of the reorder buffer: sorted entry cells, time total, output register.
// Depends on ocrb_pkg.
module ocrb_dp import ocrb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic                  cfg_wr_en,
  input  logic [INTERVAL_W-1:0] cfg_wr_data,
  input  logic                  operation,
  input  logic [ID_W-1:0]       chunk_id,
  input  logic [TS_W-1:0]       chunk_timestamp,
  input  logic [HANDLE_W-1:0]   payload_handle,
  input  logic [SIZE_W-1:0]     payload_size,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  under_budget,
  output logic                  push_refused,
  output logic                  pop_valid,
  output logic [ID_W-1:0]       out_id,
  output logic [TS_W-1:0]       out_timestamp,
  output logic [HANDLE_W-1:0]   out_handle,
  output logic [SIZE_W-1:0]     out_size,
  output logic [COUNT_W-1:0]    entry_count
);

  op_t                   op;
  entry_t                new_ent;
  entry_t                ent     [BUFFER_DEPTH];
  entry_t                up_src  [BUFFER_DEPTH];
  entry_t                down_src[BUFFER_DEPTH];
  logic [BUFFER_DEPTH-1:0] gt;
  logic [BUFFER_DEPTH-1:0] prev_gt;
  logic [COUNT_W-1:0]    count, count_next;
  logic [TOTAL_W-1:0]    total, total_next;
  logic [INTERVAL_W-1:0] interval;
  logic                  full, do_push, do_pop, under;
  logic signed [REMAIN_W-1:0] remain;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= op_t'(operation);
      new_ent <= '{id: chunk_id, ts: chunk_timestamp, handle: payload_handle,
                   size: payload_size};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= '0;
    end else if (cfg_wr_en) begin
      interval <= cfg_wr_data;
    end
  end

  assign full    = (count == COUNT_W'(BUFFER_DEPTH));
  assign do_push = cmd.exec && (op == OP_PUSH) && !full;
  assign do_pop  = cmd.exec && (op == OP_POP) && (count != '0);
  assign prev_gt = {gt[BUFFER_DEPTH-2:0], 1'b0};

  genvar k;
  generate
    for (k = 0; k < BUFFER_DEPTH; k++) begin : g_cell
      assign gt[k] = (COUNT_W'(k) < count) && (ent[k].id > new_ent.id);
      if (k == 0) begin : g_head
        assign up_src[k] = new_ent;
      end else begin : g_body
        assign up_src[k] = ent[k-1];
      end
      if (k == BUFFER_DEPTH - 1) begin : g_tail
        assign down_src[k] = ent[k];
      end else begin : g_mid
        assign down_src[k] = ent[k+1];
      end
      always_ff @(posedge clk) begin
        if (do_push && (prev_gt[k] || gt[k] || COUNT_W'(k) == count)) begin
          ent[k] <= prev_gt[k] ? up_src[k] : new_ent;
        end else if (do_pop) begin
          ent[k] <= down_src[k];
        end
      end
    end
  endgenerate

  assign remain = $signed(REMAIN_W'(BUDGET_LIMIT - CHUNK_TIME))
                - $signed({{(REMAIN_W-TOTAL_W){total[TOTAL_W-1]}}, total});
  assign under  = remain > $signed({{(REMAIN_W-INTERVAL_W){1'b0}}, interval});

  always_comb begin
    count_next = count;
    total_next = total;
    if (do_push) begin
      count_next = count + COUNT_W'(1);
      total_next = total + TOTAL_W'(CHUNK_TIME);
    end else if (do_pop) begin
      count_next = count - COUNT_W'(1);
      if (count >= COUNT_W'(2)) begin
        total_next = total + {{(TOTAL_W-TS_W){1'b0}}, ent[0].ts}
                   - {{(TOTAL_W-TS_W){1'b0}}, ent[1].ts};
      end else begin
        total_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else begin
      count <= count_next;
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      under_budget  <= do_push && under;
      push_refused  <= (op == OP_PUSH) && full;
      pop_valid     <= do_pop;
      out_id        <= do_pop ? ent[0].id : '0;
      out_timestamp <= do_pop ? ent[0].ts : '0;
      out_handle    <= do_pop ? ent[0].handle : '0;
      out_size      <= do_pop ? ent[0].size : '0;
      entry_count   <= count_next;
    end
  end

  assign status.out_busy = out_valid && out_stall;

endmodule

>>> design/id_ordered_chunk_reorder_buffer.sv
// Top level of the id ordered chunk reorder buffer: controller plus datapath.
// Depends on ocrb_pkg, ocrb_ctrl, ocrb_dp and the assertion macro header.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    operation, chunk_id, chunk_timestamp,
//                                   payload_handle, payload_size
//   out      out_valid / out_stall  under_budget, push_refused, pop_valid, out_id,
//                                   out_timestamp, out_handle, out_size, entry_count
//   cfg      cfg_wr_en              cfg_wr_data (time_interval)
//
// Each beat is captured in ST_IDLE, then applied in ST_EXEC as one update of all sixteen entry cells.
// The next beat is taken while the previous result waits in the output register.
// A result stalled at the output holds the update of the following beat.
// Synchronous reset empties the buffer and clears the total and the interval.
`include "id_ordered_chunk_reorder_buffer_macros.svh"
module id_ordered_chunk_reorder_buffer import ocrb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [INTERVAL_W-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  operation,
  input  logic [ID_W-1:0]       chunk_id,
  input  logic [TS_W-1:0]       chunk_timestamp,
  input  logic [HANDLE_W-1:0]   payload_handle,
  input  logic [SIZE_W-1:0]     payload_size,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  under_budget,
  output logic                  push_refused,
  output logic                  pop_valid,
  output logic [ID_W-1:0]       out_id,
  output logic [TS_W-1:0]       out_timestamp,
  output logic [HANDLE_W-1:0]   out_handle,
  output logic [SIZE_W-1:0]     out_size,
  output logic [COUNT_W-1:0]    entry_count
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ocrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ocrb_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .operation       (operation),
    .chunk_id        (chunk_id),
    .chunk_timestamp (chunk_timestamp),
    .payload_handle  (payload_handle),
    .payload_size    (payload_size),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .under_budget    (under_budget),
    .push_refused    (push_refused),
    .pop_valid       (pop_valid),
    .out_id          (out_id),
    .out_timestamp   (out_timestamp),
    .out_handle      (out_handle),
    .out_size        (out_size),
    .entry_count     (entry_count)
  );

  `OCRB_ASSERT(a_pop_flags, clk, rst, out_valid && pop_valid |-> !under_budget && !push_refused)
  `OCRB_ASSERT(a_refused_full, clk, rst, out_valid && push_refused |-> entry_count == COUNT_W'(BUFFER_DEPTH))
  `OCRB_ASSERT(a_count_range, clk, rst, out_valid |-> entry_count <= COUNT_W'(BUFFER_DEPTH))
  `OCRB_ASSERT_NEXT(a_busy_after_beat, clk, rst, in_valid && !in_stall, in_stall && cmd.exec == !status.out_busy)

endmodule
